// File: hdl/ppdt_pkg.sv
// Package for the pixel peak decay trail: field widths, register map codes,
// the decay table built at elaboration and the per-channel helper functions.
// Depends on nothing; used by every module of the block but ppdt_ram.
package ppdt_pkg;

  localparam int ChanW   = 8;
  localparam int ColorW  = 24;
  localparam int IndexW  = 16;
  localparam int FactorW = 11;
  localparam int DecayW  = 13;
  localparam int ProdW   = FactorW + DecayW;
  localparam int FracW   = 18;
  localparam int SubW    = 6;
  localparam int DataW   = 32;
  localparam int PaddrW  = 3;

  localparam logic [FactorW-1:0] FactorOne   = 11'd1024;
  localparam logic [FactorW-1:0] FactorReset = 11'd512;

  // Register index taken from the word-address bit of paddr.
  localparam logic RegFade = 1'b0;

  typedef logic [DecayW-1:0] decay_tab_t [256];

  typedef struct packed {
    logic              en;
    logic [IndexW-1:0] addr;
    logic [ColorW-1:0] data;
  } wr_req_t;

  // Largest k with (2k-1)^2 * 10^6 <= 4 * 2359296 * d^3, i.e. 0.006 * d^1.5 in Q8.
  function automatic decay_tab_t build_decay_table();
    decay_tab_t         tab;
    longint unsigned    k;
    longint unsigned    lim;
    longint unsigned    odd;
    longint unsigned    d;
    k = 0;
    for (d = 0; d < 256; d++) begin
      lim = 64'd9437184 * d * d * d;
      odd = 2 * k + 1;
      while (odd * odd * 64'd1000000 <= lim) begin
        k   = k + 1;
        odd = 2 * k + 1;
      end
      tab[d[7:0]] = DecayW'(k);
    end
    return tab;
  endfunction

  localparam decay_tab_t DecayTable = build_decay_table();

  function automatic logic [ChanW-1:0] brightness(input logic [ColorW-1:0] c);
    logic [ChanW-1:0] m;
    m = (c[23:16] > c[15:8]) ? c[23:16] : c[15:8];
    return (m > c[7:0]) ? m : c[7:0];
  endfunction

  function automatic logic [ChanW-1:0] fade_channel(input logic [ChanW-1:0] stored,
                                                    input logic [ChanW-1:0] fresh,
                                                    input logic [SubW-1:0]  sub);
    logic [ChanW-1:0] faded;
    faded = (stored > {2'b00, sub}) ? stored - {2'b00, sub} : '0;
    return (faded > fresh) ? faded : fresh;
  endfunction

endpackage

// File: hdl/ppdt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module ppdt_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ppdt_cfg.sv
// APB-style configuration register block holding the fade factor.
// Depends on ppdt_pkg.
module ppdt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppdt_pkg::PaddrW-1:0]    paddr,
  input  logic [ppdt_pkg::DataW-1:0]     pwdata,
  output logic [ppdt_pkg::DataW-1:0]     prdata,
  output logic                           pready,
  output logic [ppdt_pkg::FactorW-1:0]   fade_o
);
  import ppdt_pkg::*;

  logic [FactorW-1:0] fade_q, fade_d;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegFade);

  always_comb begin
    fade_d = fade_q;
    if (wr_en) begin
      fade_d = pwdata[FactorW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q <= FactorReset;
    end else begin
      fade_q <= fade_d;
    end
  end

  assign prdata = (paddr[2] == RegFade) ? {{(DataW-FactorW){1'b0}}, fade_q} : '0;
  assign fade_o = fade_q;

endmodule

// File: hdl/ppdt_pipe.sv
// Read-modify-write datapath: brightness and table lookup, factor multiply,
// fade and write-back, followed by the output register. Depends on ppdt_pkg.
module ppdt_pipe (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [ppdt_pkg::IndexW-1:0]    index_i,
  input  logic                           inside_i,
  input  logic [ppdt_pkg::ColorW-1:0]    color_i,
  input  logic [ppdt_pkg::FactorW-1:0]   fade_i,
  input  logic [ppdt_pkg::ColorW-1:0]    rdata_i,
  output logic                           advance_o,
  output logic                           hazard_o,
  output ppdt_pkg::wr_req_t              wr_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ppdt_pkg::ColorW-1:0]    out_color_o
);
  import ppdt_pkg::*;

  logic              s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic [IndexW-1:0] s1_idx_q, s2_idx_q, s3_idx_q;
  logic              s1_in_q, s2_in_q, s3_in_q;
  logic [ColorW-1:0] s1_col_q, s2_col_q, s3_col_q;
  logic [ColorW-1:0] s2_sto_q, s3_sto_q;
  logic              s2_dark_q, s3_dark_q;
  logic [DecayW-1:0] s2_tval_q;
  logic [ProdW-1:0]  s3_prod_q;
  logic [ColorW-1:0] out_col_q;

  logic              advance;
  logic [ColorW-1:0] s1_sto;
  logic [ChanW-1:0]  s1_bs, s1_bn;
  logic              s1_dark;
  logic [DecayW-1:0] s1_tval;
  logic [FactorW-1:0] s2_fac;
  logic [ProdW-1:0]  s2_prod;
  logic [SubW-1:0]   s3_sub;
  logic [ColorW-1:0] s3_res;

  assign advance = !out_vld_q || out_ready_i;

  always_comb begin
    s1_sto  = s1_in_q ? rdata_i : '0;
    s1_bs   = brightness(s1_sto);
    s1_bn   = brightness(s1_col_q);
    s1_dark = s1_bn < s1_bs;
    s1_tval = DecayTable[s1_bs - s1_bn];
  end

  always_comb begin
    s2_fac  = (fade_i > FactorOne) ? FactorOne : fade_i;
    s2_prod = ProdW'(s2_fac) * ProdW'(s2_tval_q);
  end

  always_comb begin
    s3_sub = s3_prod_q[ProdW-1:FracW] + SubW'(|s3_prod_q[FracW-1:0]);
    s3_res = s3_col_q;
    if (s3_dark_q) begin
      s3_res = {fade_channel(s3_sto_q[23:16], s3_col_q[23:16], s3_sub),
                fade_channel(s3_sto_q[15:8],  s3_col_q[15:8],  s3_sub),
                fade_channel(s3_sto_q[7:0],   s3_col_q[7:0],   s3_sub)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q  <= accept_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_idx_q  <= index_i;
      s1_in_q   <= inside_i;
      s1_col_q  <= color_i;
      s2_idx_q  <= s1_idx_q;
      s2_in_q   <= s1_in_q;
      s2_col_q  <= s1_col_q;
      s2_sto_q  <= s1_sto;
      s2_dark_q <= s1_dark;
      s2_tval_q <= s1_tval;
      s3_idx_q  <= s2_idx_q;
      s3_in_q   <= s2_in_q;
      s3_col_q  <= s2_col_q;
      s3_sto_q  <= s2_sto_q;
      s3_dark_q <= s2_dark_q;
      s3_prod_q <= s2_prod;
      out_col_q <= s3_res;
    end
  end

  assign hazard_o = (s1_vld_q && s1_in_q && s1_idx_q == index_i) ||
                    (s2_vld_q && s2_in_q && s2_idx_q == index_i) ||
                    (s3_vld_q && s3_in_q && s3_idx_q == index_i);

  assign wr_o.en   = advance && s3_vld_q && s3_in_q;
  assign wr_o.addr = s3_idx_q;
  assign wr_o.data = s3_res;

  assign advance_o   = advance;
  assign out_valid_o = out_vld_q;
  assign out_color_o = out_col_q;

endmodule

// File: hdl/pixel_peak_decay_trail.sv
// Pixel peak decay trail: per-pixel fade of darker pixels against a frame store.
// A result word passes stages s1, s2, s3 and the output register before it is offered;
// one word per cycle is taken while no result word is held back, except that a word
// whose pixel is still in the three pipeline stages waits until that write-back has been
// made. After reset the store is cleared, one entry per cycle, over all min(FRAME_PIXELS,
// 65536) entries, during which no word is taken; configuration writes still are.
module pixel_peak_decay_trail #(
  parameter int FRAME_PIXELS = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppdt_pkg::PaddrW-1:0]    paddr,
  input  logic [ppdt_pkg::DataW-1:0]     pwdata,
  output logic [ppdt_pkg::DataW-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ppdt_pkg::IndexW-1:0]    pixel_index_i,
  input  logic [ppdt_pkg::ColorW-1:0]    pixel_color_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ppdt_pkg::ColorW-1:0]    out_color_o
);
  import ppdt_pkg::*;

  localparam int StoreDepth = (FRAME_PIXELS < (1 << IndexW)) ? FRAME_PIXELS : (1 << IndexW);
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreDepth - 1);

  logic [FactorW-1:0] fade;
  logic               advance, hazard, accept, in_store;
  wr_req_t            wr;
  logic [ColorW-1:0]  rdata;

  logic               clr_busy_q, clr_busy_d;
  logic [AddrW-1:0]   clr_addr_q, clr_addr_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [ColorW-1:0]  ram_wdata;

  ppdt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fade_o  (fade)
  );

  assign in_store   = {1'b0, pixel_index_i} < (IndexW+1)'(StoreDepth);
  assign in_ready_o = advance && !clr_busy_q && !hazard;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LastAddr) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign ram_we    = clr_busy_q || wr.en;
  assign ram_waddr = clr_busy_q ? clr_addr_q : wr.addr[AddrW-1:0];
  assign ram_wdata = clr_busy_q ? '0 : wr.data;

  ppdt_ram #(
    .Width (ColorW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (pixel_index_i[AddrW-1:0]),
    .rdata_o (rdata)
  );

  ppdt_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .index_i     (pixel_index_i),
    .inside_i    (in_store),
    .color_i     (pixel_color_i),
    .fade_i      (fade),
    .rdata_i     (rdata),
    .advance_o   (advance),
    .hazard_o    (hazard),
    .wr_o        (wr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_color_o (out_color_o)
  );

endmodule
